FILE: rtl/ods_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reset constants for the oscillator discipline supervisor.
// No dependencies; imported by every module of the block.
package ods_pkg;

    // Time base width default (seconds counter)
    localparam int DEF_TIME_WIDTH = 40;

    // Field widths
    localparam int CORR_W   = 32;
    localparam int DTAU_W   = 20;
    localparam int TAU_W    = 16;
    localparam int IVL_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int OUT_BITS = 78;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Alarm word bit: tuning out of range
    localparam int TUNING_ALARM_BIT = 18;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_PH0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_PH1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_PH2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IVL_PH0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IVL_PH1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IVL_PH2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIM = 3'd6;

    // Configuration reset values
    localparam logic [TAU_W-1:0] RST_TAU_PH0  = 16'd50;
    localparam logic [TAU_W-1:0] RST_TAU_PH1  = 16'd500;
    localparam logic [TAU_W-1:0] RST_TAU_PH2  = 16'd10000;
    localparam logic [IVL_W-1:0] RST_IVL_PH0  = 24'd600;
    localparam logic [IVL_W-1:0] RST_IVL_PH1  = 24'd7200;
    localparam logic [IVL_W-1:0] RST_IVL_PH2  = 24'd86400;
    localparam logic [IVL_W-1:0] RST_HOLD_LIM = 24'd86400;

    // Discipline phases
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    typedef enum logic [1:0] {
        CLASS_UNCAL  = 2'd0,
        CLASS_CALIB  = 2'd1,
        CLASS_HOLD   = 2'd2,
        CLASS_LOCKED = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_TRACK = 2'd1,
        MODE_HOLD  = 2'd2,
        MODE_CALIB = 2'd3
    } t_mode;

    // Configuration register file
    typedef struct packed {
        logic [TAU_W-1:0] tau_ph0;
        logic [TAU_W-1:0] tau_ph1;
        logic [TAU_W-1:0] tau_ph2;
        logic [IVL_W-1:0] ivl_ph0;
        logic [IVL_W-1:0] ivl_ph1;
        logic [IVL_W-1:0] ivl_ph2;
        logic [IVL_W-1:0] hold_lim;
    } t_cfg;

    // Schedule state (start time travels separately, its width is a parameter)
    typedef struct packed {
        logic [1:0] phase;
        t_class     clk_class;
        t_mode      mode;
        logic       ready;
    } t_sched;

    // Non-time fields of one poll
    typedef struct packed {
        logic                     telemetry_ok;
        logic [31:0]              alarm_bits;
        logic signed [CORR_W-1:0] last_correction;
        logic [DTAU_W-1:0]        device_tau;
        logic                     discipline_enabled;
        logic                     fix_valid;
    } t_poll;

    // One result beat
    typedef struct packed {
        logic signed [CORR_W-1:0] fine_correction;
        logic [DTAU_W-1:0]        coarse_tau;
        logic                     latch_request;
        logic                     disable_before_latch;
        logic                     tau_write;
        logic [TAU_W-1:0]         tau_value;
        logic [1:0]               osc_class;
        logic [1:0]               discipline_state;
        logic                     hold_armed;
        logic [1:0]               phase_index;
    } t_result;

endpackage

FILE: rtl/oscillator_discipline_supervisor.sv
`timescale 1ns / 1ps
// Oscillator discipline supervisor: top level with poll/result streams and config port.
// Depends on ods_pkg and ods_step.
//
// Usage:
//  - Slave stream s_axis: one beat is one control poll (telemetry, fix status, times).
//  - Master stream m_axis: one result beat per poll (correction, tau, latch and tau
//    write requests, clock class, discipline state, phase).
//  - Config port: i_cfg_valid/o_cfg_ready with a register index and 24-bit data;
//    always ready; write only while no poll is in flight.
// Pipeline: a poll is registered in the input stage on accept, evaluated against the
//  schedule state from that register, and its result registered in the result stage
//  once that stage is free, which raises m_axis_tvalid.
// Throughput: one poll per cycle while results are taken. The schedule state is updated
//  in the same cycle as the result register, so the next poll sees it without a gap; the
//  path is set by two 40-bit elapsed-time subtract-and-compare blocks.
// Reset (i_rst_n low, synchronous): both stages empty, schedule at phase 0,
//  class calibrating, state init, config registers at their defaults.
// Stall: while m_axis_tready is low the result beat holds, one more poll may wait in
//  the input stage, then s_axis_tready drops until the result is taken.
module oscillator_discipline_supervisor #(
    parameter int TIME_WIDTH = ods_pkg::DEF_TIME_WIDTH,
    localparam int S_BITS = 87 + 2 * TIME_WIDTH,
    localparam int S_W    = ((S_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Poll stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit up: telemetry_ok, alarm_bits[32], last_correction[32],
    // device_tau[20], discipline_enabled, fix_valid, last_fix_time[TW], now_time[TW]
    input  logic [S_W-1:0]                 s_axis_tdata,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit up: fine_correction[32], coarse_tau[20], latch_request,
    // disable_before_latch, tau_write, tau_value[16], osc_class[2],
    // discipline_state[2], hold_armed, phase_index[2], zero pad
    output logic [ods_pkg::OUT_W-1:0]      m_axis_tdata,
    // Config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ods_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ods_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import ods_pkg::*;

    localparam int LF_LO  = 87;
    localparam int NOW_LO = 87 + TIME_WIDTH;

    logic                  r_s1_valid;
    t_poll                 r_s1_poll;
    logic [TIME_WIDTH-1:0] r_s1_last_fix;
    logic [TIME_WIDTH-1:0] r_s1_now;
    logic                  r_out_valid;
    t_result               r_out;
    t_sched                r_sched;
    logic [TIME_WIDTH-1:0] r_phase_start;
    t_cfg                  r_cfg;

    t_poll                 in_poll;
    t_sched                n_sched;
    logic [TIME_WIDTH-1:0] n_phase_start;
    t_result               n_out;
    logic                  out_load;

    // Unpack the poll beat
    assign in_poll.telemetry_ok       = s_axis_tdata[0];
    assign in_poll.alarm_bits         = s_axis_tdata[32:1];
    assign in_poll.last_correction    = s_axis_tdata[64:33];
    assign in_poll.device_tau         = s_axis_tdata[84:65];
    assign in_poll.discipline_enabled = s_axis_tdata[85];
    assign in_poll.fix_valid          = s_axis_tdata[86];

    // Handshake: result register frees up when empty or being taken
    assign out_load      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_load;
    assign o_cfg_ready   = 1'b1;

    ods_step #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_step (
        .i_poll        (r_s1_poll),
        .i_last_fix    (r_s1_last_fix),
        .i_now         (r_s1_now),
        .i_sched       (r_sched),
        .i_phase_start (r_phase_start),
        .i_cfg         (r_cfg),
        .o_sched       (n_sched),
        .o_phase_start (n_phase_start),
        .o_result      (n_out)
    );

    // Control, schedule state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_sched.phase     <= PHASE_0;
            r_sched.clk_class <= CLASS_CALIB;
            r_sched.mode      <= MODE_INIT;
            r_sched.ready     <= 1'b0;
            r_phase_start     <= '0;
            r_cfg.tau_ph0     <= RST_TAU_PH0;
            r_cfg.tau_ph1     <= RST_TAU_PH1;
            r_cfg.tau_ph2     <= RST_TAU_PH2;
            r_cfg.ivl_ph0     <= RST_IVL_PH0;
            r_cfg.ivl_ph1     <= RST_IVL_PH1;
            r_cfg.ivl_ph2     <= RST_IVL_PH2;
            r_cfg.hold_lim    <= RST_HOLD_LIM;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_sched       <= n_sched;
                    r_phase_start <= n_phase_start;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TAU_PH0:  r_cfg.tau_ph0  <= i_cfg_data[TAU_W-1:0];
                    CFG_TAU_PH1:  r_cfg.tau_ph1  <= i_cfg_data[TAU_W-1:0];
                    CFG_TAU_PH2:  r_cfg.tau_ph2  <= i_cfg_data[TAU_W-1:0];
                    CFG_IVL_PH0:  r_cfg.ivl_ph0  <= i_cfg_data;
                    CFG_IVL_PH1:  r_cfg.ivl_ph1  <= i_cfg_data;
                    CFG_IVL_PH2:  r_cfg.ivl_ph2  <= i_cfg_data;
                    CFG_HOLD_LIM: r_cfg.hold_lim <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_poll     <= in_poll;
            r_s1_last_fix <= s_axis_tdata[LF_LO +: TIME_WIDTH];
            r_s1_now      <= s_axis_tdata[NOW_LO +: TIME_WIDTH];
        end
        if (out_load && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    // Pack the result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}},
                            r_out.phase_index,
                            r_out.hold_armed,
                            r_out.discipline_state,
                            r_out.osc_class,
                            r_out.tau_value,
                            r_out.tau_write,
                            r_out.disable_before_latch,
                            r_out.latch_request,
                            r_out.coarse_tau,
                            r_out.fine_correction};

endmodule

FILE: rtl/ods_step.sv
`timescale 1ns / 1ps
// Per-poll decision logic: latch detection, schedule restart/advance, class update.
// Purely combinational; depends on ods_pkg.
module ods_step #(
    parameter int TIME_WIDTH = ods_pkg::DEF_TIME_WIDTH
) (
    input  ods_pkg::t_poll    i_poll,
    input  logic [TIME_WIDTH-1:0] i_last_fix,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  ods_pkg::t_sched   i_sched,
    input  logic [TIME_WIDTH-1:0] i_phase_start,
    input  ods_pkg::t_cfg     i_cfg,
    output ods_pkg::t_sched   o_sched,
    output logic [TIME_WIDTH-1:0] o_phase_start,
    output ods_pkg::t_result  o_result
);
    import ods_pkg::*;

    logic [TIME_WIDTH-1:0] age_diff;
    logic [TIME_WIDTH-1:0] run_diff;
    logic [IVL_W-1:0]      ivl_sel;
    logic                  aged;
    logic                  run_out;
    logic                  latch;
    logic                  restart;
    logic                  advance;
    logic                  adjust;
    logic [1:0]            phase_n;
    t_sched                sched_n;

    // Wrapped elapsed times; negative differences never exceed a limit
    assign age_diff = i_now - i_last_fix;
    assign run_diff = i_now - i_phase_start;
    assign ivl_sel  = (i_sched.phase == PHASE_0) ? i_cfg.ivl_ph0 : i_cfg.ivl_ph1;
    assign aged     = !age_diff[TIME_WIDTH-1] &&
                      (age_diff > {{(TIME_WIDTH-IVL_W){1'b0}}, i_cfg.hold_lim});
    assign run_out  = !run_diff[TIME_WIDTH-1] &&
                      (run_diff > {{(TIME_WIDTH-IVL_W){1'b0}}, ivl_sel});

    // Tuning alarm with zero correction asks for a latch
    assign latch   = i_poll.alarm_bits[TUNING_ALARM_BIT] &&
                     (i_poll.last_correction == '0);
    assign restart = !i_poll.fix_valid || latch;
    // After a restart the start time equals now, so the phase cannot run out
    assign advance = !restart && (i_sched.phase != PHASE_2) && run_out;
    assign adjust  = restart ? ((i_sched.phase != PHASE_0) || aged) : advance;
    assign phase_n = restart ? PHASE_0 : (i_sched.phase + {1'b0, advance});

    // Next class/mode/ready
    always_comb begin
        sched_n       = i_sched;
        sched_n.phase = phase_n;
        if (!restart && (i_sched.clk_class == CLASS_HOLD ||
                         i_sched.clk_class == CLASS_UNCAL)) begin
            sched_n.clk_class = CLASS_CALIB;
            sched_n.mode      = MODE_TRACK;
        end
        if (adjust) begin
            if (!i_poll.fix_valid) begin
                sched_n.clk_class = (i_sched.clk_class == CLASS_CALIB || aged) ?
                                    CLASS_UNCAL : CLASS_HOLD;
                sched_n.mode      = MODE_HOLD;
            end else if (phase_n == PHASE_0) begin
                sched_n.clk_class = CLASS_CALIB;
                sched_n.mode      = MODE_TRACK;
            end else begin
                sched_n.clk_class = CLASS_LOCKED;
                sched_n.mode      = MODE_CALIB;
            end
            sched_n.ready = (phase_n == PHASE_2);
        end
    end

    // Failed telemetry leaves state untouched
    assign o_sched       = i_poll.telemetry_ok ? sched_n : i_sched;
    assign o_phase_start = (i_poll.telemetry_ok && restart) ? i_now : i_phase_start;

    // Result beat
    always_comb begin
        o_result = '0;
        if (i_poll.telemetry_ok) begin
            o_result.fine_correction      = i_poll.last_correction;
            o_result.coarse_tau           = i_poll.device_tau;
            o_result.latch_request        = latch;
            o_result.disable_before_latch = latch && i_poll.discipline_enabled;
            o_result.tau_write            = adjust;
        end else begin
            o_result.fine_correction = '1;
            o_result.coarse_tau      = '0;
        end
        case (o_sched.phase)
            PHASE_0: o_result.tau_value = i_cfg.tau_ph0;
            PHASE_1: o_result.tau_value = i_cfg.tau_ph1;
            default: o_result.tau_value = i_cfg.tau_ph2;
        endcase
        o_result.osc_class        = o_sched.clk_class;
        o_result.discipline_state = o_sched.mode;
        o_result.hold_armed       = o_sched.ready;
        o_result.phase_index      = o_sched.phase;
    end

endmodule

FILE: rtl/ods_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the supervisor's result stream, bound to the top level.
// Depends on ods_pkg and oscillator_discipline_supervisor.
module ods_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [ods_pkg::OUT_W-1:0] m_axis_tdata
);
    import ods_pkg::*;

    logic       latch_req;
    logic       dis_latch;
    logic [1:0] cls;
    logic [1:0] mode;
    logic       ready;
    logic [1:0] phase;

    assign latch_req = m_axis_tdata[52];
    assign dis_latch = m_axis_tdata[53];
    assign cls       = m_axis_tdata[72:71];
    assign mode      = m_axis_tdata[74:73];
    assign ready     = m_axis_tdata[75];
    assign phase     = m_axis_tdata[77:76];

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

    // Holdover-ready tracks the final phase
    a_ready_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (ready == (phase == PHASE_2)))
        else $error("hold_armed disagrees with phase");

    // A latch restarts the schedule; disable only comes with a latch
    a_latch_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((!latch_req || phase == PHASE_0) && (!dis_latch || latch_req)))
        else $error("latch result inconsistent");

    // Locked class always pairs with calibration state
    a_locked_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((cls == CLASS_LOCKED) == (mode == MODE_CALIB)))
        else $error("class and state out of step");

endmodule

bind oscillator_discipline_supervisor ods_checker u_ods_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tb_oscillator_discipline_supervisor.sv
`timescale 1ns / 1ps
// Self-checking bench for the oscillator discipline supervisor: directed polls, then
// random polls under several register settings. Depends on ods_pkg and the RTL top.
module tb_oscillator_discipline_supervisor;

    import ods_pkg::*;

    localparam int TW          = DEF_TIME_WIDTH;
    localparam int POLL_BITS   = 87 + 2 * TW;
    localparam int S_WIDTH     = ((POLL_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_CAP  = 200;
    localparam int RAND_PER_SET = 170;
    localparam int STEADY_ITEMS = 60;
    localparam int DIR_ROWS    = 23;

    localparam logic [TW-1:0] TIME_MAX = '1;
    localparam logic [31:0]   TUNE_ALARM = 32'h1 << TUNING_ALARM_BIT;

    // One poll, fields in stream order
    typedef struct packed {
        logic                     telemetry_ok;
        logic [31:0]              alarm_bits;
        logic signed [CORR_W-1:0] last_correction;
        logic [DTAU_W-1:0]        device_tau;
        logic                     discipline_enabled;
        logic                     fix_valid;
        logic [TW-1:0]            last_fix_time;
        logic [TW-1:0]            now_time;
    } t_tb_poll;

    // Directed row: poll plus an optional hand-written result
    typedef struct packed {
        t_tb_poll poll;
        logic     golden;
        t_result  gold;
    } t_dir_row;

    // Failed poll right after reset: sentinel correction, registers at reset
    localparam t_result FAIL_AT_RESET = '{-32'sd1, 20'd0, 1'b0, 1'b0, 1'b0, RST_TAU_PH0,
                                          CLASS_CALIB, MODE_INIT, 1'b0, PHASE_0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_WIDTH-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // Predicted block state and register file
    t_cfg          disc_cfg;
    logic [1:0]    sched_phase;
    logic [TW-1:0] sched_start;
    t_class        sched_class;
    t_mode         sched_mode;
    logic          sched_ready;

    t_result       pending_results[$];
    t_dir_row      dir_tab [DIR_ROWS];
    logic [TW-1:0] poll_clock;
    bit            idle_on = 1'b0;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    oscillator_discipline_supervisor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_cfg default_settings();
        return '{RST_TAU_PH0, RST_TAU_PH1, RST_TAU_PH2, RST_IVL_PH0, RST_IVL_PH1,
                 RST_IVL_PH2, RST_HOLD_LIM};
    endfunction

    // Wrapped difference read as signed; a negative span never exceeds a limit
    function automatic bit span_exceeds(logic [TW-1:0] later, logic [TW-1:0] earlier,
                                        logic [IVL_W-1:0] lim);
        logic [TW-1:0] span;
        span = later - earlier;
        if (span[TW-1])
            return 1'b0;
        return span > lim;
    endfunction

    // Schedule update for one accepted poll; returns the result it must produce
    task automatic predict_discipline(input t_tb_poll p, output t_result r);
        bit               aged;
        bit               latch;
        bit               adjust;
        logic [IVL_W-1:0] dwell;
        r = '0;
        latch = 1'b0;
        adjust = 1'b0;
        if (!p.telemetry_ok) begin
            r.fine_correction = -32'sd1;
            r.coarse_tau = '0;
        end else begin
            aged = span_exceeds(p.now_time, p.last_fix_time, disc_cfg.hold_lim);
            r.fine_correction = p.last_correction;
            r.coarse_tau = p.device_tau;
            // tuning out of range with a zero correction asks for a latch
            if (p.alarm_bits[TUNING_ALARM_BIT] && p.last_correction == 0) begin
                latch = 1'b1;
                r.disable_before_latch = p.discipline_enabled;
                adjust = 1'b1;
            end
            // fix loss or latch restarts the schedule; adjust is recomputed even on latch
            if (!p.fix_valid || latch) begin
                adjust = (sched_phase != PHASE_0) || aged;
                sched_phase = PHASE_0;
                sched_start = p.now_time;
            end else if (sched_class == CLASS_HOLD || sched_class == CLASS_UNCAL) begin
                sched_class = CLASS_CALIB;
                sched_mode = MODE_TRACK;
            end
            // dwell run out: next phase; the final phase stays
            if (sched_phase != PHASE_2) begin
                dwell = (sched_phase == PHASE_0) ? disc_cfg.ivl_ph0 : disc_cfg.ivl_ph1;
                if (span_exceeds(p.now_time, sched_start, dwell)) begin
                    adjust = 1'b1;
                    sched_phase = sched_phase + 2'd1;
                end
            end
            if (adjust) begin
                if (!p.fix_valid) begin
                    sched_class = (sched_class == CLASS_CALIB || aged) ? CLASS_UNCAL
                                                                       : CLASS_HOLD;
                    sched_mode = MODE_HOLD;
                end else if (sched_phase == PHASE_0) begin
                    sched_class = CLASS_CALIB;
                    sched_mode = MODE_TRACK;
                end else begin
                    sched_class = CLASS_LOCKED;
                    sched_mode = MODE_CALIB;
                end
                sched_ready = (sched_phase == PHASE_2);
            end
        end
        r.latch_request = latch;
        r.tau_write = adjust;
        case (sched_phase)
            PHASE_0: r.tau_value = disc_cfg.tau_ph0;
            PHASE_1: r.tau_value = disc_cfg.tau_ph1;
            default: r.tau_value = disc_cfg.tau_ph2;
        endcase
        r.osc_class = sched_class;
        r.discipline_state = sched_mode;
        r.hold_armed = sched_ready;
        r.phase_index = sched_phase;
    endtask

    // Mostly plausible timing around the dwell and holdover edges, some wild values
    function automatic t_tb_poll random_poll();
        t_tb_poll         p;
        int unsigned      pick;
        logic [IVL_W-1:0] dwell;
        dwell = (sched_phase == PHASE_0) ? disc_cfg.ivl_ph0 : disc_cfg.ivl_ph1;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            poll_clock = poll_clock + $urandom_range(0, 3);
        else if (pick < 70)
            poll_clock = sched_start + dwell - 1 + $urandom_range(0, 2);
        else if (pick < 85)
            poll_clock = poll_clock + $urandom_range(0, 32'h1FF_FFFF);
        else if (pick < 92)
            poll_clock = poll_clock - $urandom_range(1, 5);
        else
            poll_clock = TW'({$urandom, $urandom});
        p.now_time = poll_clock;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            p.last_fix_time = poll_clock - $urandom_range(0, 5);
        else if (pick < 80)
            p.last_fix_time = poll_clock - disc_cfg.hold_lim - 1 + $urandom_range(0, 2);
        else if (pick < 90)
            p.last_fix_time = poll_clock + $urandom_range(1, 5);
        else
            p.last_fix_time = TW'({$urandom, $urandom});
        p.telemetry_ok = ($urandom_range(0, 99) < 93);
        p.fix_valid = ($urandom_range(0, 99) < 85);
        p.alarm_bits = $urandom;
        p.alarm_bits[TUNING_ALARM_BIT] = ($urandom_range(0, 99) < 20);
        p.last_correction = ($urandom_range(0, 99) < 40) ? 32'sd0 : $urandom;
        p.device_tau = DTAU_W'($urandom);
        p.discipline_enabled = 1'($urandom);
        return p;
    endfunction

    // Drive one poll beat; call and return at a falling edge
    task automatic send_poll(input t_tb_poll p, input logic golden, input t_result gold);
        t_result want;
        while (idle_on && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata <= {{(S_WIDTH - POLL_BITS){1'b0}}, p.now_time, p.last_fix_time,
                         p.fix_valid, p.discipline_enabled, p.device_tau,
                         p.last_correction, p.alarm_bits, p.telemetry_ok};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_discipline(p, want);
        pending_results.push_back(golden ? gold : want);
        @(negedge i_clk);
    endtask

    // Register write beat; valid stays up across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_TAU_PH0:  disc_cfg.tau_ph0 = val[TAU_W-1:0];
            CFG_TAU_PH1:  disc_cfg.tau_ph1 = val[TAU_W-1:0];
            CFG_TAU_PH2:  disc_cfg.tau_ph2 = val[TAU_W-1:0];
            CFG_IVL_PH0:  disc_cfg.ivl_ph0 = val;
            CFG_IVL_PH1:  disc_cfg.ivl_ph1 = val;
            CFG_IVL_PH2:  disc_cfg.ivl_ph2 = val;
            CFG_HOLD_LIM: disc_cfg.hold_lim = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Wait for the block to go idle, then reprogram every register
    task automatic load_settings(input t_cfg c);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        // upper data bits of the tau registers are don't-care, keep them moving
        write_reg(CFG_TAU_PH0, {8'($urandom), c.tau_ph0});
        write_reg(CFG_TAU_PH1, {8'($urandom), c.tau_ph1});
        write_reg(CFG_TAU_PH2, {8'($urandom), c.tau_ph2});
        write_reg(CFG_IVL_PH0, c.ivl_ph0);
        write_reg(CFG_IVL_PH1, c.ivl_ph1);
        write_reg(CFG_IVL_PH2, c.ivl_ph2);
        write_reg(CFG_HOLD_LIM, c.hold_lim);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < REPORT_CAP)
                $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: random back-pressure
    always @(negedge i_clk)
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 24);

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.fine_correction      = m_axis_tdata[31:0];
            got.coarse_tau           = m_axis_tdata[51:32];
            got.latch_request        = m_axis_tdata[52];
            got.disable_before_latch = m_axis_tdata[53];
            got.tau_write            = m_axis_tdata[54];
            got.tau_value            = m_axis_tdata[70:55];
            got.osc_class            = m_axis_tdata[72:71];
            got.discipline_state     = m_axis_tdata[74:73];
            got.hold_armed           = m_axis_tdata[75];
            got.phase_index          = m_axis_tdata[77:76];
            if (pending_results.size() == 0) begin
                if (mismatch_count < REPORT_CAP)
                    $display("%0t: result beat with none expected, got %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("fine_correction", want.fine_correction, got.fine_correction);
                check_field("coarse_tau", want.coarse_tau, got.coarse_tau);
                check_field("latch_request", want.latch_request, got.latch_request);
                check_field("disable_before_latch", want.disable_before_latch,
                            got.disable_before_latch);
                check_field("tau_write", want.tau_write, got.tau_write);
                check_field("tau_value", want.tau_value, got.tau_value);
                check_field("osc_class", want.osc_class, got.osc_class);
                check_field("discipline_state", want.discipline_state,
                            got.discipline_state);
                check_field("hold_armed", want.hold_armed, got.hold_armed);
                check_field("phase_index", want.phase_index, got.phase_index);
            end
        end
    end

    initial begin : main_seq
        t_cfg c;
        // ok, alarm, correction, device tau, disc enable, fix, last fix, now
        dir_tab = '{
            // failed telemetry right after reset, all zero and all ones
            '{'{1'b0, 32'h0, 32'sh0, 20'h0, 1'b0, 1'b0, 0, 0}, 1'b1, FAIL_AT_RESET},
            '{'{1'b0, 32'hFFFF_FFFF, -32'sd1, 20'hFFFFF, 1'b1, 1'b1, TIME_MAX, TIME_MAX},
              1'b1, FAIL_AT_RESET},
            // quiet polls, correction extremes, dwell exactly reached
            '{'{1'b1, 32'h0, 32'sh7FFF_FFFF, 20'hFFFFF, 1'b0, 1'b1, 0, 0}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sh8000_0000, 20'h0, 1'b1, 1'b1, 600, 600}, 1'b0, '0},
            // one past the dwell: phase one, then on to phase two
            '{'{1'b1, 32'h1, 32'sd5, 20'h7, 1'b0, 1'b1, 601, 601}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd6, 20'h8, 1'b0, 1'b1, 7801, 7801}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd7, 20'h9, 1'b0, 1'b1, 7802, 7802}, 1'b0, '0},
            // final phase holds at the top of the time range
            '{'{1'b1, 32'h0, 32'sd8, 20'hA, 1'b1, 1'b1, TIME_MAX, TIME_MAX}, 1'b0, '0},
            // fix loss from locked, fresh fix age: holdover; fix back: calibrating
            '{'{1'b1, 32'h0, 32'sd1, 20'h1, 1'b0, 1'b0, 10000, 10000}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd1, 20'h1, 1'b0, 1'b1, 10001, 10001}, 1'b0, '0},
            // fix age one past and exactly at the holdover limit
            '{'{1'b1, 32'h0, 32'sd2, 20'h2, 1'b0, 1'b0, 113599, 200000}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd2, 20'h2, 1'b0, 1'b0, 213600, 300000}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd3, 20'h3, 1'b0, 1'b1, 300001, 300001}, 1'b0, '0},
            // latch in phase zero: adjust recomputed to zero
            '{'{1'b1, TUNE_ALARM, 32'sd0, 20'h4, 1'b1, 1'b1, 300002, 300002}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd9, 20'h5, 1'b1, 1'b1, 300603, 300603}, 1'b0, '0},
            // latch out of phase one with disciplining off, all alarm bits set
            '{'{1'b1, 32'hFFFF_FFFF, 32'sd0, 20'h6, 1'b0, 1'b1, 300604, 300604}, 1'b0, '0},
            // tuning alarm with nonzero correction, other alarms with zero correction
            '{'{1'b1, TUNE_ALARM, 32'sd1, 20'h7, 1'b1, 1'b1, 300605, 300605}, 1'b0, '0},
            '{'{1'b1, ~TUNE_ALARM, 32'sd0, 20'h8, 1'b1, 1'b1, 300606, 300606}, 1'b0, '0},
            // last fix in the future, then time going back past the phase start
            '{'{1'b1, 32'h0, 32'sd4, 20'h9, 1'b0, 1'b0, 400005, 400000}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd4, 20'h9, 1'b0, 1'b1, 399000, 399000}, 1'b0, '0},
            // time wraps through zero
            '{'{1'b1, 32'h0, 32'sd5, 20'hA, 1'b0, 1'b0, TIME_MAX, 3}, 1'b0, '0},
            '{'{1'b1, 32'h0, 32'sd5, 20'hA, 1'b0, 1'b1, 605, 605}, 1'b0, '0},
            // fix loss from locked with a stale fix: uncalibrated
            '{'{1'b1, 32'h0, 32'sd6, 20'hB, 1'b0, 1'b0, 0, 1000000}, 1'b0, '0}
        };

        disc_cfg = default_settings();
        sched_phase = PHASE_0;
        sched_start = '0;
        sched_class = CLASS_CALIB;
        sched_mode = MODE_INIT;
        sched_ready = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows at the reset settings
        foreach (dir_tab[k])
            send_poll(dir_tab[k].poll, dir_tab[k].golden, dir_tab[k].gold);
        poll_clock = 1000000;

        // random polls under each register setting; the first runs at reset values
        for (int set = 0; set < 6; set++) begin
            case (set)
                1: c = '0;
                2: c = '1;
                3: c = '{TAU_W'($urandom), TAU_W'($urandom), TAU_W'($urandom),
                         IVL_W'($urandom), IVL_W'($urandom), IVL_W'($urandom),
                         IVL_W'($urandom)};
                4: c = '{TAU_W'($urandom), TAU_W'($urandom), TAU_W'($urandom),
                         IVL_W'($urandom_range(0, 40)), IVL_W'($urandom_range(0, 40)),
                         IVL_W'($urandom_range(0, 40)), IVL_W'($urandom_range(0, 300))};
                5: c = default_settings();
                default: c = disc_cfg;
            endcase
            if (set != 0)
                load_settings(c);
            for (int n = 0; n < RAND_PER_SET; n++) begin
                idle_on = (n >= STEADY_ITEMS);
                send_poll(random_poll(), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then wait for stray beats
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ods_pkg.sv
rtl/ods_step.sv
rtl/oscillator_discipline_supervisor.sv
rtl/ods_checker.sv
sim/tb_oscillator_discipline_supervisor.sv
